// ===== hdl/protobuf_wire_value_decoder_top_macros.svh =====
// ----------------------------------------------------------------------------
// protobuf wire value decoder assertion macros
// clocked checks shared by the decoder, all disabled during reset
// ----------------------------------------------------------------------------
`ifndef PROTOBUF_WIRE_VALUE_DECODER_TOP_MACROS_SVH
`define PROTOBUF_WIRE_VALUE_DECODER_TOP_MACROS_SVH

// same-cycle implication
`define PBWD_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PBWD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/pbwd_pkg.sv =====
// ----------------------------------------------------------------------------
// pbwd_pkg
// types and constants shared by the protobuf wire value decoder
// ----------------------------------------------------------------------------
package pbwd_pkg;

   localparam int PBWD_LENGTH_WIDTH = 32;
   localparam int POS_WIDTH         = 4;
   localparam logic [POS_WIDTH-1:0] MAX_VARINT_BYTES = 4'd10;

   typedef enum logic [2:0] {
      KIND_VARINT  = 3'd0,
      KIND_ZIGZAG  = 3'd1,
      KIND_TAG     = 3'd2,
      KIND_FIXED32 = 3'd3,
      KIND_FIXED64 = 3'd4,
      KIND_BYTES   = 3'd5
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_CUT_OFF   = 3'd1,
      ST_OVERLONG  = 3'd2,
      ST_TOO_LARGE = 3'd3,
      ST_ZERO_TAG  = 3'd4
   } status_type;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic [2:0]  opcode;
      logic [15:0] payload_limit;
      logic        end_of_parcel;
   } req_word_type;

   typedef struct packed {
      logic [63:0] value;
      logic        is_payload_byte;
      logic        value_done;
      logic [2:0]  status;
   } rsp_word_type;

   typedef struct packed {
      logic         valid;
      req_word_type word;
   } req_slot_type;

   typedef struct packed {
      logic         valid;
      rsp_word_type word;
   } rsp_slot_type;

endpackage

// ===== hdl/protobuf_wire_value_decoder_top.sv =====
// ----------------------------------------------------------------------------
// protobuf_wire_value_decoder_top
// decodes protobuf wire values from a parcel byte stream, one byte per word
// ----------------------------------------------------------------------------
// req_ carries one parcel byte per word with the kind opcode, the byte-string
// length limit and an end-of-parcel flag; opcode and limit count only on the
// first byte of a value. rsp_ carries zero or one result word per byte:
// decoded varint, zigzag, tag or fixed value, the length of a byte string,
// or one payload byte, with a done flag and a status.
// An accepted word goes to the input register, where the decode logic works on
// it, and the result register loads the decoded word when the core takes it.
// Throughput is one word per cycle while the result is taken, set by the single
// decode pass over the byte accumulator, length counter and value state.
// Reset clears the value state; the next accepted word starts a new value.
// While rsp_ready is low the result register holds its word, the input
// register fills and req_ready then drops until the result is taken.
// ----------------------------------------------------------------------------
`include "protobuf_wire_value_decoder_top_macros.svh"

module protobuf_wire_value_decoder_top
   import pbwd_pkg::*;
#(
   parameter int LENGTH_WIDTH = PBWD_LENGTH_WIDTH
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_word_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_data
);

   req_slot_type in_slot;
   rsp_slot_type out_slot;
   logic         take;
   logic         out_free;

   pbwd_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .take      (take),
      .in_slot   (in_slot)
   );

   pbwd_core #(
      .LENGTH_WIDTH (LENGTH_WIDTH)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .in_slot  (in_slot),
      .out_free (out_free),
      .take     (take),
      .out_slot (out_slot)
   );

   pbwd_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .out_slot  (out_slot),
      .out_free  (out_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   `PBWD_ASSERT_SAME(a_no_overwrite, out_slot.valid, out_free, "result register overwritten")
   `PBWD_ASSERT_NEXT(a_accept_held, req_valid && req_ready, in_slot.valid, "accepted word lost")
   `PBWD_ASSERT_SAME(a_error_ends, rsp_valid && rsp_data.status != ST_OK, rsp_data.value_done, "error status without value end")

endmodule

// ===== hdl/pbwd_in_stage.sv =====
// ----------------------------------------------------------------------------
// pbwd_in_stage
// input register: holds one request word until the decode core takes it
// ----------------------------------------------------------------------------
module pbwd_in_stage
   import pbwd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_word_type req_data,
   input  logic         take,
   output req_slot_type in_slot
);

   logic         valid_ff;
   logic         valid_in;
   req_word_type word_ff;
   logic         load;

   assign req_ready = !valid_ff || take;
   assign load      = req_valid && req_ready;
   assign valid_in  = load ? 1'b1 : (take ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= req_data;
      end
   end

   assign in_slot.valid = valid_ff;
   assign in_slot.word  = word_ff;

endmodule

// ===== hdl/pbwd_core.sv =====
// ----------------------------------------------------------------------------
// pbwd_core
// value state and single-pass decode of one parcel byte per cycle while the result register is free
// ----------------------------------------------------------------------------
module pbwd_core
   import pbwd_pkg::*;
#(
   parameter int LENGTH_WIDTH = PBWD_LENGTH_WIDTH
)
(
   input  logic         clock,
   input  logic         reset,
   input  req_slot_type in_slot,
   input  logic         out_free,
   output logic         take,
   output rsp_slot_type out_slot
);

   logic                    in_value_ff, in_value_in;
   logic                    in_payload_ff, in_payload_in;
   kind_type                kind_ff, kind_in;
   logic [15:0]             limit_ff, limit_in;
   logic [63:0]             acc_ff, acc_in;
   logic [POS_WIDTH-1:0]    pos_ff, pos_in;
   logic [LENGTH_WIDTH-1:0] rem_ff, rem_in;

   logic                    start, known_op, done;
   kind_type                kind_eff;
   logic [15:0]             lim_eff;
   logic [63:0]             acc_eff;
   logic [POS_WIDTH-1:0]    pos_eff;
   logic [LENGTH_WIDTH-1:0] rem_eff, rem_dec, len;
   logic                    pay_eff;
   logic [7:0]              b;
   logic                    eop;
   logic [63:0]             fix_acc, var_acc, zz, tag;
   logic [POS_WIDTH-1:0]    fix_pos, var_pos;
   logic                    fix_last, var_room, too_large;
   logic [6:0]              sh;
   rsp_word_type            res;
   logic                    res_valid;

   assign take = in_slot.valid && out_free;

   // effective state: a fresh value starts from cleared state
   always_comb begin
      b        = in_slot.word.data_byte;
      eop      = in_slot.word.end_of_parcel;
      start    = !in_value_ff;
      known_op = in_slot.word.opcode <= KIND_BYTES;
      kind_eff = start ? kind_type'(in_slot.word.opcode) : kind_ff;
      lim_eff  = start ? in_slot.word.payload_limit : limit_ff;
      acc_eff  = start ? 64'd0 : acc_ff;
      pos_eff  = start ? '0 : pos_ff;
      rem_eff  = start ? '0 : rem_ff;
      pay_eff  = start ? 1'b0 : in_payload_ff;
   end

   // datapath candidates
   always_comb begin
      fix_acc  = pos_eff[3] ? acc_eff : (acc_eff | (64'(b) << {pos_eff[2:0], 3'b000}));
      fix_pos  = pos_eff + 4'd1;
      fix_last = (kind_eff == KIND_FIXED32) ? (fix_pos >= 4'd4) : (fix_pos >= 4'd8);
      sh       = ({3'b000, pos_eff} << 3) - {3'b000, pos_eff};
      var_room = pos_eff < MAX_VARINT_BYTES;
      var_acc  = (var_room && sh < 7'd64) ? (acc_eff | (64'(b[6:0]) << sh)) : acc_eff;
      var_pos  = var_room ? (pos_eff + 4'd1) : pos_eff;
      zz       = {1'b0, var_acc[63:1]} ^ {64{var_acc[0]}};
      tag      = {32'd0, var_acc[31:0]};
      len      = var_acc[LENGTH_WIDTH-1:0];
      too_large = len > LENGTH_WIDTH'(lim_eff);
      rem_dec  = rem_eff - LENGTH_WIDTH'(1);
   end

   // next state and result
   always_comb begin
      in_value_in   = in_value_ff;
      in_payload_in = in_payload_ff;
      kind_in       = kind_ff;
      limit_in      = limit_ff;
      acc_in        = acc_ff;
      pos_in        = pos_ff;
      rem_in        = rem_ff;
      res           = '0;
      res_valid     = 1'b0;
      done          = 1'b0;
      if (take && !(start && !known_op)) begin
         in_value_in   = 1'b1;
         kind_in       = kind_eff;
         limit_in      = lim_eff;
         acc_in        = acc_eff;
         pos_in        = pos_eff;
         rem_in        = rem_eff;
         in_payload_in = pay_eff;
         if (pay_eff) begin
            rem_in              = rem_dec;
            res_valid           = 1'b1;
            res.value           = 64'(b);
            res.is_payload_byte = 1'b1;
            if (rem_dec == '0) begin
               done = 1'b1;
            end else if (eop) begin
               done       = 1'b1;
               res.status = ST_CUT_OFF;
            end
         end else if (kind_eff == KIND_FIXED32 || kind_eff == KIND_FIXED64) begin
            acc_in = fix_acc;
            pos_in = fix_pos;
            if (fix_last) begin
               res_valid = 1'b1;
               done      = 1'b1;
               res.value = fix_acc;
            end else if (eop) begin
               res_valid  = 1'b1;
               done       = 1'b1;
               res.status = ST_CUT_OFF;
            end
         end else begin
            acc_in = var_acc;
            pos_in = var_pos;
            if (!b[7]) begin
               res_valid = 1'b1;
               done      = 1'b1;
               case (kind_eff)
                  KIND_ZIGZAG: begin
                     res.value = zz;
                  end
                  KIND_TAG: begin
                     res.value = tag;
                     if (tag == 64'd0) begin
                        res.status = ST_ZERO_TAG;
                     end
                  end
                  KIND_BYTES: begin
                     res.value = 64'(len);
                     if (too_large) begin
                        res.status = ST_TOO_LARGE;
                     end else if (len != '0) begin
                        done          = 1'b0;
                        rem_in        = len;
                        in_payload_in = 1'b1;
                        acc_in        = '0;
                        pos_in        = '0;
                     end
                  end
                  default: begin
                     res.value = var_acc;
                  end
               endcase
            end else if (var_pos >= MAX_VARINT_BYTES) begin
               res_valid  = 1'b1;
               done       = 1'b1;
               res.status = (kind_eff == KIND_TAG && eop) ? ST_CUT_OFF : ST_OVERLONG;
            end else if (eop) begin
               res_valid  = 1'b1;
               done       = 1'b1;
               res.status = ST_CUT_OFF;
            end
         end
         if (done) begin
            in_value_in   = 1'b0;
            in_payload_in = 1'b0;
            acc_in        = '0;
            pos_in        = '0;
            rem_in        = '0;
         end
      end
      res.value_done = done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_value_ff   <= 1'b0;
         in_payload_ff <= 1'b0;
      end else begin
         in_value_ff   <= in_value_in;
         in_payload_ff <= in_payload_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      limit_ff <= limit_in;
      acc_ff   <= acc_in;
      pos_ff   <= pos_in;
      rem_ff   <= rem_in;
   end

   assign out_slot.valid = res_valid;
   assign out_slot.word  = res;

endmodule

// ===== hdl/pbwd_out_stage.sv =====
// ----------------------------------------------------------------------------
// pbwd_out_stage
// result register: holds one response word until the receiver takes it
// ----------------------------------------------------------------------------
module pbwd_out_stage
   import pbwd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  rsp_slot_type out_slot,
   output logic         out_free,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_data
);

   logic         valid_ff;
   logic         valid_in;
   rsp_word_type word_ff;

   assign out_free = !valid_ff || rsp_ready;
   assign valid_in = out_slot.valid ? 1'b1 : (rsp_ready ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_slot.valid) begin
         word_ff <= out_slot.word;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = word_ff;

endmodule
